[hdl/qayt_pkg.sv]
// shared constants, types and the arctangent table of the yaw tracker
package qayt_pkg;

  localparam int QW       = 24;   // quaternion part after dropping 8 fraction bits
  localparam int PW       = 48;   // width of one quaternion product
  localparam int VW       = 56;   // cordic vector width
  localparam int ZW       = 36;   // cordic angle accumulator width
  localparam int MW       = 35;   // shared multiplier operand width
  localparam int OUT_W    = 144;  // packed result width
  localparam int CORDIC_STEPS = 31;

  localparam logic signed [ZW-1:0] PI_Q30 = 36'sd3373259426;

  localparam logic signed [21:0] QUARTER_TURN = 22'sd11520;
  localparam logic signed [21:0] HALF_TURN    = 22'sd23040;
  localparam logic signed [16:0] FULL_TURN    = 17'sd46080;
  localparam logic signed [32:0] TRACK_LIMIT  = 33'sd12800;

  // q30 radians to 1/128 degree: * 36672, round, / (5 * 2^30)
  localparam logic signed [MW-1:0] DEG_SCALE   = 35'sd36672;
  localparam logic [50:0]          HALF_DEN    = 51'd2684354560;
  localparam logic signed [MW-1:0] RECIP_FIVE  = 35'sd1677722;

  // configuration register indexes
  localparam logic REG_ENABLE    = 1'b0;
  localparam logic REG_GYRO_BIAS = 1'b1;

  typedef enum logic [1:0] {
    ANG_PITCH = 2'd0,
    ANG_ROLL  = 2'd1,
    ANG_YAW   = 2'd2
  } angle_sel_t;

  function automatic logic [30:0] atan_entry(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd8;
      5'd28: v = 31'd4;
      5'd29: v = 31'd2;
      5'd30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

[hdl/qayt_cordic.sv]
// vectoring cordic: one micro-rotation per cycle, angle in q30 radians
module qayt_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [qayt_pkg::VW-1:0]    x_in,
  input  logic signed [qayt_pkg::VW-1:0]    y_in,
  output logic                              done,
  output logic signed [qayt_pkg::ZW-1:0]    z_out
);

  logic                           busy_r;
  logic                           done_r;
  logic                           zero_r;
  logic [4:0]                     cnt_r;
  logic signed [qayt_pkg::VW-1:0] x_r;
  logic signed [qayt_pkg::VW-1:0] y_r;
  logic signed [qayt_pkg::ZW-1:0] z_r;
  logic signed [qayt_pkg::VW-1:0] dx;
  logic signed [qayt_pkg::VW-1:0] dy;
  logic signed [qayt_pkg::ZW-1:0] da;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign da = $signed({5'd0, qayt_pkg::atan_entry(cnt_r)});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'(qayt_pkg::CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= 5'd0;
      zero_r <= (x_in == '0) && (y_in == '0);
      // left half plane: rotate by pi first
      if (x_in < 0) begin
        x_r <= -x_in;
        y_r <= -y_in;
        z_r <= (y_in >= 0) ? qayt_pkg::PI_Q30 : -qayt_pkg::PI_Q30;
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= '0;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (y_r >= 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + da;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - da;
      end
    end
  end

  assign done  = done_r;
  assign z_out = zero_r ? '0 : z_r;

endmodule

[hdl/quaternion_attitude_yaw_tracker.sv]
// top level: quaternion to pitch, roll and yaw with turn counting and gyro integration
// While processing is enabled a request passes through the square root (31 steps) and
// the cordic, whose 31 micro-rotations run three times, once each for pitch, roll and
// yaw; while it is off the request goes straight to the result register. A single
// shared multiplier forms the ten quaternion products, the square for the square root
// and the degree scaling. The block is not ready while a request is in work; the
// result waits in an output register, so a new request may be taken while the
// previous result is still unread. Angles are in 1/128 degree; yaw is wrapped into
// 0..360 and also tracked across turns.
module quaternion_attitude_yaw_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // quat_w, quat_x, quat_y, quat_z, gyro_z_raw
  input  logic [qayt_pkg::OUT_W-1:0]       in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // pitch_angle, roll_angle, yaw_wrapped, yaw_unwrapped, yaw_tracked,
  // gyro_z_integral, one pad bit
  output logic [qayt_pkg::OUT_W-1:0]       out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [15:0]                      cfg_data
);

  typedef enum logic [15:0] {
    ST_IDLE      = 16'h0001,
    ST_PROD      = 16'h0002,
    ST_SCALC     = 16'h0004,
    ST_SSQ       = 16'h0008,
    ST_SQRT_INIT = 16'h0010,
    ST_SQRT      = 16'h0020,
    ST_CPRE      = 16'h0040,
    ST_CWAIT     = 16'h0080,
    ST_U1        = 16'h0100,
    ST_U2        = 16'h0200,
    ST_U3        = 16'h0400,
    ST_U4        = 16'h0800,
    ST_TURN      = 16'h1000,
    ST_TRACK     = 16'h2000,
    ST_ACC       = 16'h4000,
    ST_DONE      = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  logic                              enable_r;
  logic signed [15:0]                bias_r;

  logic signed [qayt_pkg::QW-1:0]    q0_r, q1_r, q2_r, q3_r;
  logic signed [15:0]                gyro_r;
  logic signed [qayt_pkg::PW-1:0]    prod_r [10];
  logic [4:0]                        k_r;
  logic signed [31:0]                s_r;
  logic [61:0]                       n_r;
  logic [61:0]                       root_r;
  qayt_pkg::angle_sel_t              ang_r;
  logic                              z_neg_r;
  logic [20:0]                       t_r;

  logic signed [qayt_pkg::MW-1:0]    mul_a, mul_b;
  logic signed [69:0]                mul_p_r;

  logic signed [14:0]                pitch_r;
  logic signed [15:0]                roll_r;
  logic signed [15:0]                yaw_raw_r;
  logic [15:0]                       cur_yaw_r;
  logic signed [31:0]                unwr_r;

  logic [15:0]                       prev_yaw_r;
  logic signed [31:0]                prev_unwr_r;
  logic signed [15:0]                turn_cnt_r;
  logic signed [31:0]                tracked_r;
  logic signed [31:0]                integral_r;
  logic                              seen_r;

  logic                              out_tvalid_r;
  logic [qayt_pkg::OUT_W-1:0]        out_tdata_r;

  logic                              cordic_start;
  logic                              cordic_done;
  logic signed [qayt_pkg::VW-1:0]    cx, cy;
  logic signed [qayt_pkg::ZW-1:0]    cz;

  logic                              accept;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      bias_r   <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        qayt_pkg::REG_ENABLE:    enable_r <= cfg_data[0];
        qayt_pkg::REG_GYRO_BIAS: bias_r   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_PROD: begin
        case (k_r)
          5'd0: begin mul_a = 35'(q0_r); mul_b = 35'(q2_r); end
          5'd1: begin mul_a = 35'(q1_r); mul_b = 35'(q3_r); end
          5'd2: begin mul_a = 35'(q2_r); mul_b = 35'(q3_r); end
          5'd3: begin mul_a = 35'(q0_r); mul_b = 35'(q1_r); end
          5'd4: begin mul_a = 35'(q1_r); mul_b = 35'(q1_r); end
          5'd5: begin mul_a = 35'(q2_r); mul_b = 35'(q2_r); end
          5'd6: begin mul_a = 35'(q1_r); mul_b = 35'(q2_r); end
          5'd7: begin mul_a = 35'(q0_r); mul_b = 35'(q3_r); end
          5'd8: begin mul_a = 35'(q0_r); mul_b = 35'(q0_r); end
          5'd9: begin mul_a = 35'(q3_r); mul_b = 35'(q3_r); end
          default: ;
        endcase
      end
      ST_SSQ: begin
        mul_a = 35'(s_r);
        mul_b = 35'(s_r);
      end
      ST_U1: begin
        mul_a = $signed({1'b0, (cz < 0) ? 34'(-cz) : 34'(cz)});
        mul_b = qayt_pkg::DEG_SCALE;
      end
      ST_U3: begin
        mul_a = $signed({14'd0, t_r});
        mul_b = qayt_pkg::RECIP_FIVE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
  end

  // cordic input vector
  always_comb begin
    cx = '0;
    cy = '0;
    case (ang_r)
      qayt_pkg::ANG_PITCH: begin
        cy = 56'(s_r);
        cx = $signed({24'd0, root_r[31:0]});
      end
      qayt_pkg::ANG_ROLL: begin
        cy = (56'(prod_r[2]) + 56'(prod_r[3])) <<< 1;
        cx = (56'sd1 <<< 44) - ((56'(prod_r[4]) + 56'(prod_r[5])) <<< 1);
      end
      default: begin
        cy = (56'(prod_r[6]) + 56'(prod_r[7])) <<< 1;
        cx = 56'(prod_r[8]) + 56'(prod_r[4]) - 56'(prod_r[5]) - 56'(prod_r[9]);
      end
    endcase
  end

  assign cordic_start = (state_r == ST_CPRE);

  qayt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .x_in  (cx),
    .y_in  (cy),
    .done  (cordic_done),
    .z_out (cz)
  );

  // datapath helpers
  logic signed [48:0]  s_diff;
  logic signed [48:0]  s_shift;
  logic [61:0]         sq_bit;
  logic [61:0]         sq_trial;
  logic [50:0]         t_sum;
  logic [19:0]         deg_mag;
  logic signed [21:0]  deg_val;
  logic signed [16:0]  yaw_w17;
  logic [15:0]         yaw_w;
  logic [15:0]         prev_w;
  logic signed [17:0]  yaw_err;
  logic signed [33:0]  rate_sum;
  logic signed [31:0]  tc32;
  logic signed [31:0]  turn_off;
  logic signed [32:0]  det;
  logic signed [33:0]  track_sum;

  assign s_diff   = 49'(prod_r[0]) - 49'(prod_r[1]);
  assign s_shift  = s_diff >>> 13;
  assign sq_bit   = 62'd1 << {k_r, 1'b0};
  assign sq_trial = root_r + sq_bit;
  assign t_sum    = mul_p_r[50:0] + qayt_pkg::HALF_DEN;
  assign deg_mag  = mul_p_r[42:23];
  assign deg_val  = z_neg_r ? -$signed({2'b0, deg_mag}) : $signed({2'b0, deg_mag});
  assign yaw_w17  = (yaw_raw_r < 0) ? 17'(yaw_raw_r) + qayt_pkg::FULL_TURN
                                    : 17'(yaw_raw_r);
  assign yaw_w    = yaw_w17[15:0];
  assign prev_w   = seen_r ? prev_yaw_r : yaw_w;
  assign yaw_err  = $signed({2'b0, yaw_w}) - $signed({2'b0, prev_w});
  assign rate_sum = 34'(integral_r) + 34'(gyro_r) - 34'(bias_r);
  assign tc32     = 32'(turn_cnt_r);
  // 46080 = 2^15 + 2^13 + 2^12 + 2^10
  assign turn_off = (tc32 <<< 15) + (tc32 <<< 13) + (tc32 <<< 12) + (tc32 <<< 10);
  assign det      = 33'(unwr_r) - 33'(prev_unwr_r);
  assign track_sum = 34'(tracked_r) + 34'(det);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (accept) state_nxt = enable_r ? ST_PROD : ST_DONE;
      ST_PROD:      if (k_r == 5'd10) state_nxt = ST_SCALC;
      ST_SCALC:     state_nxt = ST_SSQ;
      ST_SSQ:       state_nxt = ST_SQRT_INIT;
      ST_SQRT_INIT: state_nxt = ST_SQRT;
      ST_SQRT:      if (k_r == 5'd0) state_nxt = ST_CPRE;
      ST_CPRE:      state_nxt = ST_CWAIT;
      ST_CWAIT:     if (cordic_done) state_nxt = ST_U1;
      ST_U1:        state_nxt = ST_U2;
      ST_U2:        state_nxt = ST_U3;
      ST_U3:        state_nxt = ST_U4;
      ST_U4:        state_nxt = (ang_r == qayt_pkg::ANG_YAW) ? ST_TURN : ST_CPRE;
      ST_TURN:      state_nxt = ST_TRACK;
      ST_TRACK:     state_nxt = ST_ACC;
      ST_ACC:       state_nxt = ST_DONE;
      ST_DONE:      if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        q0_r    <= $signed(in_tdata[31:8]);
        q1_r    <= $signed(in_tdata[63:40]);
        q2_r    <= $signed(in_tdata[95:72]);
        q3_r    <= $signed(in_tdata[127:104]);
        gyro_r  <= $signed(in_tdata[143:128]);
        k_r     <= 5'd0;
        pitch_r <= '0;
        roll_r  <= '0;
      end
      ST_PROD: begin
        if (k_r != 5'd0) prod_r[4'(k_r - 5'd1)] <= mul_p_r[qayt_pkg::PW-1:0];
        k_r <= k_r + 5'd1;
      end
      ST_SCALC: begin
        if (s_shift > 49'sd1073741824)       s_r <= 32'sd1073741824;
        else if (s_shift < -49'sd1073741824) s_r <= -32'sd1073741824;
        else                                 s_r <= 32'(s_shift);
      end
      ST_SQRT_INIT: begin
        n_r    <= (62'd1 << 60) - mul_p_r[61:0];
        root_r <= '0;
        k_r    <= 5'd30;
      end
      ST_SQRT: begin
        if (n_r >= sq_trial) begin
          n_r    <= n_r - sq_trial;
          root_r <= (root_r >> 1) + sq_bit;
        end else begin
          root_r <= root_r >> 1;
        end
        k_r   <= k_r - 5'd1;
        ang_r <= qayt_pkg::ANG_PITCH;
      end
      ST_U1: z_neg_r <= (cz < 0);
      ST_U2: t_r <= t_sum[50:30];
      ST_U4: begin
        case (ang_r)
          qayt_pkg::ANG_PITCH: begin
            if (deg_val > qayt_pkg::QUARTER_TURN)       pitch_r <= 15'(qayt_pkg::QUARTER_TURN);
            else if (deg_val < -qayt_pkg::QUARTER_TURN) pitch_r <= 15'(-qayt_pkg::QUARTER_TURN);
            else                                        pitch_r <= 15'(deg_val);
            ang_r <= qayt_pkg::ANG_ROLL;
          end
          qayt_pkg::ANG_ROLL: begin
            if (deg_val > qayt_pkg::HALF_TURN)       roll_r <= 16'(qayt_pkg::HALF_TURN);
            else if (deg_val < -qayt_pkg::HALF_TURN) roll_r <= 16'(-qayt_pkg::HALF_TURN);
            else                                     roll_r <= 16'(deg_val);
            ang_r <= qayt_pkg::ANG_YAW;
          end
          default: begin
            if (deg_val > qayt_pkg::HALF_TURN)       yaw_raw_r <= 16'(qayt_pkg::HALF_TURN);
            else if (deg_val < -qayt_pkg::HALF_TURN) yaw_raw_r <= 16'(-qayt_pkg::HALF_TURN);
            else                                     yaw_raw_r <= 16'(deg_val);
          end
        endcase
      end
      ST_TURN:  cur_yaw_r <= yaw_w;
      ST_TRACK: unwr_r <= turn_off + $signed({16'd0, cur_yaw_r});
      default: ;
    endcase
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_yaw_r  <= '0;
      prev_unwr_r <= '0;
      turn_cnt_r  <= '0;
      tracked_r   <= '0;
      integral_r  <= '0;
      seen_r      <= 1'b0;
    end else begin
      if (state_r == ST_TURN) begin
        seen_r <= 1'b1;
        if (yaw_err < -18'sd23040 && turn_cnt_r != 16'sd32767)
          turn_cnt_r <= turn_cnt_r + 16'sd1;
        else if (yaw_err > 18'sd23040 && turn_cnt_r != -16'sd32768)
          turn_cnt_r <= turn_cnt_r - 16'sd1;
        if (rate_sum > 34'sd2147483647)       integral_r <= 32'sh7fffffff;
        else if (rate_sum < -34'sd2147483648) integral_r <= 32'sh80000000;
        else                                  integral_r <= 32'(rate_sum);
      end
      if (state_r == ST_ACC) begin
        // only small steps of the unwrapped yaw count toward the tracked yaw
        if (det > -qayt_pkg::TRACK_LIMIT && det < qayt_pkg::TRACK_LIMIT) begin
          if (track_sum > 34'sd2147483647)       tracked_r <= 32'sh7fffffff;
          else if (track_sum < -34'sd2147483648) tracked_r <= 32'sh80000000;
          else                                   tracked_r <= 32'(track_sum);
        end
        prev_yaw_r  <= cur_yaw_r;
        prev_unwr_r <= unwr_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= {1'b0, integral_r, tracked_r, prev_unwr_r, prev_yaw_r, roll_r, pitch_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
